// File: rtl/core/lseq_pkg.sv
// Shared types and constants of the on/off light sequencer.
`default_nettype none

package lseq_pkg;

   // Command codes of a request transaction
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ON     = 2'd1;
   localparam logic [1:0] CMD_OFF    = 2'd2;
   localparam logic [1:0] CMD_EFFECT = 2'd3;

   // Report kinds
   localparam logic [1:0] RPT_NONE      = 2'd0;
   localparam logic [1:0] RPT_STARTED   = 2'd1;
   localparam logic [1:0] RPT_COMPLETED = 2'd2;

   // Report actions
   localparam logic ACT_OFF = 1'b0;
   localparam logic ACT_ON  = 1'b1;

   // Off effect kinds
   localparam logic EFF_DELAYED_OFF = 1'b0;
   localparam logic EFF_DYING_LIGHT = 1'b1;

   // CSR indexes
   localparam logic [1:0] CSR_AUTO_OFF_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_AUTO_OFF_SECONDS = 2'd1;
   localparam logic [1:0] CSR_MOVEMENT_MS      = 2'd2;

   localparam int unsigned    CSR_INDEX_W      = 2;
   localparam int unsigned    CSR_DATA_W       = 16;
   localparam logic [15:0]    MOVEMENT_MS_RST  = 16'd2000;
   localparam logic [9:0]     MS_PER_SECOND    = 10'd1000;
   localparam int unsigned    AUTO_MS_W        = 26;
   localparam int unsigned    EFFECT_MS_W      = 14;
   localparam logic [13:0]    EFF_SHORT_MS     = 14'd800;
   localparam logic [13:0]    EFF_LONG_MS      = 14'd12800;
   localparam logic [13:0]    EFF_DYING_MS     = 14'd1500;

   typedef enum logic [1:0] {
      PH_OFF_DONE  = 2'd0,
      PH_ON_START  = 2'd1,
      PH_OFF_START = 2'd2,
      PH_ON_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] actor;
      logic       effect_id;
      logic [2:0] effect_variant;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [1:0] report_kind;
      logic       report_action;
      logic [7:0] report_actor;
      logic       report_by_timer;
      logic       light_on;
      logic       in_progress;
   } rsp_type;

   typedef struct packed {
      logic        auto_off_enable;
      logic [15:0] auto_off_seconds;
      logic [15:0] movement_ms;
   } cfg_type;

   // Delay of an off effect; unknown variants expire on the next tick
   function automatic logic [EFFECT_MS_W-1:0] effect_ms(input logic       id,
                                                        input logic [2:0] variant);
      logic [EFFECT_MS_W-1:0] ms;
      ms = '0;
      if (id == EFF_DELAYED_OFF) begin
         if (variant == 3'd0 || variant == 3'd1) ms = EFF_SHORT_MS;
         else if (variant == 3'd2)               ms = EFF_LONG_MS;
      end else if (id == EFF_DYING_LIGHT && variant == 3'd0) begin
         ms = EFF_DYING_MS;
      end
      return ms;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/lseq_csr.sv
// Configuration registers of the light sequencer.
`default_nettype none

module lseq_csr
   import lseq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_AUTO_OFF_ENABLE:  cfg_in.auto_off_enable  = csr_wdata[0];
            CSR_AUTO_OFF_SECONDS: cfg_in.auto_off_seconds = csr_wdata;
            CSR_MOVEMENT_MS:      cfg_in.movement_ms      = csr_wdata;
            default:              cfg_in = cfg_ff;  // drop writes past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_off_enable  <= 1'b0;
         cfg_ff.auto_off_seconds <= '0;
         cfg_ff.movement_ms      <= MOVEMENT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/lseq_in_reg.sv
// Input register stage of the light sequencer.
`default_nettype none

module lseq_in_reg
   import lseq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         item_valid,
   input  wire logic    item_take,
   output req_type      item_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || item_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) data_ff <= req_data;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/lseq_core.sv
// Phase state, one-shot timer and per-transaction decision logic.
`default_nettype none

module lseq_core
   import lseq_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 26
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   localparam int unsigned PW = (TIMER_WIDTH > AUTO_MS_W) ? TIMER_WIDTH : AUTO_MS_W;

   phase_type              phase_ff, phase_in;
   logic                   auto_armed_ff, auto_armed_in;
   logic                   effect_armed_ff, effect_armed_in;
   logic                   running_ff, running_in;
   logic [TIMER_WIDTH-1:0] left_ff, left_in;

   logic                   is_tick, is_on, is_off, is_effect;
   logic                   expire, exp_auto, exp_effect, exp_off_taken;
   logic                   exp_done_on, exp_done_off;
   logic                   req_on_taken, req_off_taken, start_off, start_move;
   logic [AUTO_MS_W-1:0]   auto_ms;
   logic [PW-1:0]          auto_ms_w;
   logic [TIMER_WIDTH-1:0] auto_ms_sat, move_ms, eff_ms;

   assign is_tick   = item.command == CMD_TICK;
   assign is_on     = item.command == CMD_ON;
   assign is_off    = item.command == CMD_OFF;
   assign is_effect = item.command == CMD_EFFECT;

   assign expire       = is_tick && running_ff && (left_ff <= TIMER_WIDTH'(1));
   assign exp_auto     = expire && auto_armed_ff;
   assign exp_effect   = expire && !auto_armed_ff && effect_armed_ff;
   // Effect expiry disarms the effect before the off is tried
   assign exp_off_taken = (exp_auto && phase_ff == PH_ON_DONE && !effect_armed_ff)
                        || (exp_effect && phase_ff == PH_ON_DONE);
   assign exp_done_off = expire && !auto_armed_ff && !effect_armed_ff
                        && phase_ff == PH_OFF_START;
   assign exp_done_on  = expire && !auto_armed_ff && !effect_armed_ff
                        && phase_ff == PH_ON_START;

   assign req_on_taken  = is_on && (phase_ff == PH_OFF_DONE || effect_armed_ff);
   assign req_off_taken = is_off && phase_ff == PH_ON_DONE && !effect_armed_ff;
   assign start_off     = req_off_taken || exp_off_taken;
   assign start_move    = req_on_taken || start_off;

   // Auto-off delay, saturated to the timer width
   assign auto_ms     = AUTO_MS_W'(cfg.auto_off_seconds) * AUTO_MS_W'(MS_PER_SECOND);
   assign auto_ms_w   = PW'(auto_ms);
   assign auto_ms_sat = (auto_ms_w > PW'({TIMER_WIDTH{1'b1}})) ? {TIMER_WIDTH{1'b1}}
                                                               : auto_ms_w[TIMER_WIDTH-1:0];
   assign move_ms     = TIMER_WIDTH'(cfg.movement_ms);
   assign eff_ms      = TIMER_WIDTH'(effect_ms(item.effect_id, item.effect_variant));

   // Phase next state
   always_comb begin
      phase_in = phase_ff;
      if (req_on_taken)      phase_in = PH_ON_START;
      else if (start_off)    phase_in = PH_OFF_START;
      else if (exp_done_off) phase_in = PH_OFF_DONE;
      else if (exp_done_on)  phase_in = PH_ON_DONE;
   end

   // Arm flags and timer
   always_comb begin
      auto_armed_in   = auto_armed_ff;
      effect_armed_in = effect_armed_ff;
      running_in      = running_ff;
      left_in         = left_ff;
      if (exp_auto || req_off_taken)      auto_armed_in = 1'b0;
      else if (exp_done_on && cfg.auto_off_enable) auto_armed_in = 1'b1;
      if (exp_effect || req_on_taken)     effect_armed_in = 1'b0;
      else if (is_effect)                 effect_armed_in = 1'b1;
      if (start_move) begin
         running_in = 1'b1;
         left_in    = move_ms;
      end else if (exp_done_on && cfg.auto_off_enable) begin
         running_in = 1'b1;
         left_in    = auto_ms_sat;
      end else if (is_effect) begin
         running_in = 1'b1;
         left_in    = eff_ms;
      end else if (expire) begin
         running_in = 1'b0;
      end else if (is_tick && running_ff) begin
         left_in = left_ff - TIMER_WIDTH'(1);
      end
   end

   // Result fields
   always_comb begin
      rsp                 = '0;
      rsp.accepted        = req_on_taken || req_off_taken;
      if (start_move)                        rsp.report_kind = RPT_STARTED;
      else if (exp_done_on || exp_done_off)  rsp.report_kind = RPT_COMPLETED;
      else                                   rsp.report_kind = RPT_NONE;
      rsp.report_action   = (req_on_taken || exp_done_on) ? ACT_ON : ACT_OFF;
      rsp.report_actor    = (req_on_taken || req_off_taken) ? item.actor : 8'd0;
      rsp.report_by_timer = exp_off_taken;
      rsp.light_on        = phase_in == PH_ON_DONE;
      rsp.in_progress     = phase_in == PH_ON_START || phase_in == PH_OFF_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_OFF_DONE;
         auto_armed_ff   <= 1'b0;
         effect_armed_ff <= 1'b0;
         running_ff      <= 1'b0;
         left_ff         <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         auto_armed_ff   <= auto_armed_in;
         effect_armed_ff <= effect_armed_in;
         running_ff      <= running_in;
         left_ff         <= left_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lseq_out_reg.sv
// Result register stage of the light sequencer.
`default_nettype none

module lseq_out_reg
   import lseq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_data,
   output logic         can_load,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Hold a waiting result until it is taken; refill in the same cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/light_onoff_sequencer_top.sv
// Top level of the on/off light sequencer.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_type  (command, actor, effect)
//   rsp_     out        rsp_valid/rsp_ready    rsp_type  (one result per request)
//   csr_     in         csr_write_en           csr_index, csr_wdata
//
// One transaction is taken per cycle unless a stalled rsp_ fills both stages; its
// result passes the input register at acceptance, then the result register.
// The phase and timer update is a single pass of compares and one counter step.
// Reset clears phase, arm flags, timer and CSRs (movement time back to 2000 ms).
// A stalled rsp_ holds the result and the input register; req_ready drops only
// when both stages are full.
`default_nettype none

module light_onoff_sequencer_top
   import lseq_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 26
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type item;
   rsp_type step_rsp;
   logic    item_valid, can_load, fire;

   assign fire = item_valid && can_load;

   lseq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   lseq_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (fire),
      .item_data  (item)
   );

   lseq_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   lseq_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (step_rsp),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_accept_is_user_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
         rsp_data.report_kind == RPT_STARTED && !rsp_data.report_by_timer
         && rsp_data.in_progress)
      else $error("accepted request without a user start report");

   a_timer_start_is_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.report_by_timer |->
         rsp_data.report_kind == RPT_STARTED && rsp_data.report_action == ACT_OFF
         && rsp_data.report_actor == 8'd0 && !rsp_data.accepted)
      else $error("timer-started action is not a plain off");

   a_complete_settles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.report_kind == RPT_COMPLETED |->
         !rsp_data.in_progress && rsp_data.light_on == rsp_data.report_action)
      else $error("completion report does not match the settled phase");

   a_item_waits: assert property (@(posedge clock) disable iff (reset)
      item_valid && !can_load |=> item_valid && $stable(item))
      else $error("pending transaction lost while result stage is full");

endmodule

`default_nettype wire

// File: tb/sv/tb_light_onoff_sequencer_top.sv
// Self-checking testbench of the on/off light sequencer: directed script, random traffic.
`timescale 1ns / 100ps

module tb_light_onoff_sequencer_top
   import lseq_pkg::*;
;

   localparam int unsigned TIMER_W = 26;
   localparam longint unsigned TIMER_CAP = (64'd1 << TIMER_W) - 1;
   localparam time HALF_PERIOD = 5ns;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 4;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Directed script: either a register write or a request with an optional fixed answer
   typedef struct packed {
      bit                     csr_write;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      req_type                req;
      bit                     typed;
      rsp_type                want;
   } plan_row_type;

   plan_row_type plan[$];
   rsp_type      pending_reports[$];
   int           mismatches = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;

   // Sequencer state as the predictor sees it
   phase_type            lamp_phase = PH_OFF_DONE;
   bit                   auto_off_pending = 1'b0;
   bit                   effect_pending = 1'b0;
   bit                   timer_live = 1'b0;
   logic [TIMER_W-1:0]   timer_ms = '0;
   cfg_type              lamp_cfg = {1'b0, 16'd0, MOVEMENT_MS_RST};

   light_onoff_sequencer_top #(
      .TIMER_WIDTH (TIMER_W)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void load_timer(input longint unsigned ms);
      timer_ms   = TIMER_W'((ms > TIMER_CAP) ? TIMER_CAP : ms);
      timer_live = 1'b1;
   endfunction

   function automatic longint unsigned effect_delay(input logic id, input logic [2:0] variant);
      if (id == EFF_DELAYED_OFF) begin
         if (variant <= 3'd1) return EFF_SHORT_MS;
         if (variant == 3'd2) return EFF_LONG_MS;
         return 0;
      end
      return (variant == 3'd0) ? EFF_DYING_MS : 0;
   endfunction

   // Start an on or off movement if the phase allows it; fill the start report
   function automatic bit begin_move(input logic action, input logic [7:0] actor,
                                     input bit by_timer, inout rsp_type r);
      phase_type nxt;
      if (action == ACT_ON && (lamp_phase == PH_OFF_DONE || effect_pending)) begin
         nxt = PH_ON_START;
         if (effect_pending) begin
            timer_live     = 1'b0;
            effect_pending = 1'b0;
         end
      end else if (action == ACT_OFF && lamp_phase == PH_ON_DONE && !effect_pending) begin
         nxt = PH_OFF_START;
         if (auto_off_pending) begin
            auto_off_pending = 1'b0;
            timer_live       = 1'b0;
         end
      end else begin
         return 1'b0;
      end
      load_timer(lamp_cfg.movement_ms);
      lamp_phase        = nxt;
      r.report_kind     = RPT_STARTED;
      r.report_action   = action;
      r.report_actor    = by_timer ? 8'd0 : actor;
      r.report_by_timer = by_timer;
      return 1'b1;
   endfunction

   function automatic void timer_expiry(inout rsp_type r);
      timer_live = 1'b0;
      if (auto_off_pending) begin
         auto_off_pending = 1'b0;
         void'(begin_move(ACT_OFF, 8'd0, 1'b1, r));
      end else if (effect_pending) begin
         effect_pending = 1'b0;
         void'(begin_move(ACT_OFF, 8'd0, 1'b1, r));
      end else if (lamp_phase == PH_OFF_START) begin
         lamp_phase      = PH_OFF_DONE;
         r.report_kind   = RPT_COMPLETED;
         r.report_action = ACT_OFF;
      end else if (lamp_phase == PH_ON_START) begin
         lamp_phase      = PH_ON_DONE;
         r.report_kind   = RPT_COMPLETED;
         r.report_action = ACT_ON;
         if (lamp_cfg.auto_off_enable) begin
            load_timer(64'(lamp_cfg.auto_off_seconds) * MS_PER_SECOND);
            auto_off_pending = 1'b1;
         end
      end
   endfunction

   function automatic rsp_type predict_report(input req_type q);
      rsp_type r;
      bit      took;
      r = '0;
      case (q.command)
         CMD_TICK: begin
            if (timer_live) begin
               if (timer_ms > 1) timer_ms = timer_ms - 1'b1;
               else timer_expiry(r);
            end
         end
         CMD_ON, CMD_OFF: begin
            took = begin_move((q.command == CMD_ON) ? ACT_ON : ACT_OFF, q.actor, 1'b0, r);
            r.accepted = took;
         end
         default: begin
            effect_pending = 1'b1;
            load_timer(effect_delay(q.effect_id, q.effect_variant));
         end
      endcase
      r.light_on    = (lamp_phase == PH_ON_DONE);
      r.in_progress = (lamp_phase == PH_ON_START) || (lamp_phase == PH_OFF_START);
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_report(input rsp_type want, input rsp_type got);
      if (got.accepted !== want.accepted) begin
         $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
         mismatches++;
      end
      if (got.report_kind !== want.report_kind) begin
         $error("report_kind: expected %0d, got %0d", want.report_kind, got.report_kind);
         mismatches++;
      end
      if (got.report_action !== want.report_action) begin
         $error("report_action: expected %0d, got %0d", want.report_action, got.report_action);
         mismatches++;
      end
      if (got.report_actor !== want.report_actor) begin
         $error("report_actor: expected %0h, got %0h", want.report_actor, got.report_actor);
         mismatches++;
      end
      if (got.report_by_timer !== want.report_by_timer) begin
         $error("report_by_timer: expected %0d, got %0d",
                want.report_by_timer, got.report_by_timer);
         mismatches++;
      end
      if (got.light_on !== want.light_on) begin
         $error("light_on: expected %0d, got %0d", want.light_on, got.light_on);
         mismatches++;
      end
      if (got.in_progress !== want.in_progress) begin
         $error("in_progress: expected %0d, got %0d", want.in_progress, got.in_progress);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("report transaction with no request pending: %h", rsp_data);
            mismatches++;
         end else begin
            check_report(pending_reports.pop_front(), rsp_data);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic req_type make_req(input logic [1:0] cmd, input logic [7:0] actor,
                                        input logic eid, input logic [2:0] variant);
      return {cmd, actor, eid, variant};
   endfunction

   // Tick with random don't-care fields
   function automatic req_type tick_req();
      return make_req(CMD_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
   endfunction

   function automatic void add_req(input logic [1:0] cmd, input logic [7:0] actor,
                                   input logic eid, input logic [2:0] variant,
                                   input bit typed = 1'b0, input rsp_type want = '0);
      plan_row_type r;
      r       = '0;
      r.req   = make_req(cmd, actor, eid, variant);
      r.typed = typed;
      r.want  = want;
      plan.push_back(r);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r           = '0;
      r.csr_write = 1'b1;
      r.csr_idx   = idx;
      r.csr_val   = val;
      plan.push_back(r);
   endfunction

   // Hold valid with the payload until the transaction is taken, then predict it
   task automatic send_req(input req_type q, input bit typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      predicted = predict_report(q);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   // Drop valid and wait until every report is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         CSR_AUTO_OFF_ENABLE:  lamp_cfg.auto_off_enable  = val[0];
         CSR_AUTO_OFF_SECONDS: lamp_cfg.auto_off_seconds = val;
         CSR_MOVEMENT_MS:      lamp_cfg.movement_ms      = val;
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a request that the current phase takes, followed by up to movement_ms + 3 ticks
   task automatic random_items(input int quota);
      req_type     q;
      int          sent;
      int unsigned burst;
      sent = 0;
      while (sent < quota) begin
         q = req_type'(14'($urandom));
         if ($urandom_range(3) != 0) begin
            if (effect_pending || lamp_phase == PH_OFF_DONE) q.command = CMD_ON;
            else if (lamp_phase == PH_ON_DONE && $urandom_range(3) != 0) q.command = CMD_OFF;
            else q.command = CMD_EFFECT;
            if (q.command == CMD_EFFECT && $urandom_range(1) == 1) begin
               q.effect_id      = EFF_DYING_LIGHT;
               q.effect_variant = 3'($urandom_range(7, 1));
            end
            burst = $urandom_range(lamp_cfg.movement_ms + 3);
         end else begin
            burst = 0;
         end
         send_req(q, 1'b0, '0);
         repeat (burst) send_req(tick_req(), 1'b0, '0);
         sent += 1 + burst;
      end
   endtask

   task automatic run_phase(input logic [15:0] movement, input logic auto_en,
                            input logic [15:0] auto_secs, input int unsigned send_pct,
                            input int unsigned recv_pct, input int quota);
      settle();
      write_csr(CSR_MOVEMENT_MS, movement);
      write_csr(CSR_AUTO_OFF_ENABLE, {15'd0, auto_en});
      write_csr(CSR_AUTO_OFF_SECONDS, auto_secs);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      random_items(quota);
   endtask

   initial begin
      // After reset: movement of 2000 ms, no auto-off
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0, 1'b1, '0);
      add_req(CMD_OFF, 8'hFF, EFF_DYING_LIGHT, 3'd7, 1'b1, '0);
      add_req(CMD_ON, 8'hFF, EFF_DELAYED_OFF, 3'd0, 1'b1,
              {1'b1, RPT_STARTED, ACT_ON, 8'hFF, 1'b0, 1'b0, 1'b1});
      add_req(CMD_ON, 8'h00, EFF_DELAYED_OFF, 3'd0, 1'b1,
              {1'b0, RPT_NONE, ACT_OFF, 8'h00, 1'b0, 1'b0, 1'b1});
      // Zero-length effect expires into a refused off while the on still moves
      add_req(CMD_EFFECT, 8'hA5, EFF_DYING_LIGHT, 3'd7);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_EFFECT, 8'h00, EFF_DELAYED_OFF, 3'd2);
      add_req(CMD_ON, 8'h5A, EFF_DELAYED_OFF, 3'd0);
      add_csr(CSR_MOVEMENT_MS, 16'd0);
      add_csr(CSR_AUTO_OFF_ENABLE, 16'd1);
      add_csr(CSR_AUTO_OFF_SECONDS, 16'd0);
      // Recover through an armed effect, complete on, then auto-off fires
      add_req(CMD_EFFECT, 8'h00, EFF_DELAYED_OFF, 3'd3);
      add_req(CMD_ON, 8'h80, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);
      // Auto-off and effect both armed: on taken, then the expiry issues a refused off
      add_req(CMD_ON, 8'h7F, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_EFFECT, 8'h00, EFF_DYING_LIGHT, 3'd0);
      add_req(CMD_ON, 8'h33, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_OFF, 8'h01, EFF_DELAYED_OFF, 3'd0);
      add_csr(CSR_MOVEMENT_MS, 16'hFFFF);
      add_csr(CSR_AUTO_OFF_SECONDS, 16'hFFFF);
      add_csr(CSR_AUTO_OFF_ENABLE, 16'd0);
      add_req(CMD_EFFECT, 8'h00, EFF_DELAYED_OFF, 3'd1);
      add_req(CMD_ON, 8'h02, EFF_DELAYED_OFF, 3'd0);
      add_req(CMD_TICK, 8'h00, EFF_DELAYED_OFF, 3'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].csr_write) begin
            settle();
            write_csr(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            send_req(plan[i].req, plan[i].typed, plan[i].want);
         end
      end

      run_phase(16'd2, 1'b0, 16'd0, 0, 0, 110);
      run_phase(16'd0, 1'b1, 16'd0, 59, 0, 110);
      run_phase(16'd5, 1'b1, 16'd0, 0, 59, 110);
      run_phase(16'd1, 1'b1, 16'hFFFF, 28, 28, 110);

      settle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lseq_pkg.sv
rtl/core/lseq_csr.sv
rtl/core/lseq_in_reg.sv
rtl/core/lseq_core.sv
rtl/core/lseq_out_reg.sv
rtl/core/light_onoff_sequencer_top.sv
tb/sv/tb_light_onoff_sequencer_top.sv
